FILE: src/tpw_pkg.sv
// shared types and constants for the tree path walker
// no dependencies
package tpw_pkg;

    localparam int NODE_W = 16;
    localparam int STEP_W = 17;
    localparam int OP_W   = 2;
    localparam int CIDX_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_START_NODE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BLD_RD1,
        S_BLD_RD2,
        S_BLD_WR,
        S_Q_DP,
        S_Q_DT,
        S_Q_SW,
        S_L1_RD,
        S_L1_CMP,
        S_L1_CHK,
        S_L2_RB,
        S_L2_CMP,
        S_F_C,
        S_F_DC,
        S_D1,
        S_D2,
        S_D3,
        S_CL_ISS,
        S_CL_WAIT,
        S_OUT
    } t_state;

endpackage

FILE: src/tpw_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/tree_path_walker_lca_unit.sv
// tree path walker: lowest common ancestor and k-th node on a path
// depends on tpw_pkg and tpw_ram
//
// An item is taken when start is high and busy is low; results come out as a one-cycle
// o_result_valid strobe and cannot be held off. A load (op 0) writes the parent and
// depth of one node and leaves the block idle. A build (op 1) visits every node for
// each level above level zero, with two reads of the ancestor memory and a write
// (S_BLD_RD1, S_BLD_RD2, S_BLD_WR) per node and level. A move (op 2) keeps the block
// busy until it emits one result; a move whose target or position is out of range,
// a load, a build and op 3 emit nothing. Each step of every walk is a dependent read
// of the ancestor memory, which has one registered read port. There is no clearing
// pass: table entries are only meaningful once loaded or built.
module tree_path_walker_lca_unit #(
    parameter int MAX_NODES   = 65535,
    parameter int LIFT_LEVELS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tpw_pkg::OP_W-1:0]    i_op,
    input  logic [tpw_pkg::NODE_W-1:0]  i_node_id,
    input  logic [tpw_pkg::NODE_W-1:0]  i_parent_id,
    input  logic [tpw_pkg::NODE_W-1:0]  i_node_depth,
    input  logic [tpw_pkg::STEP_W-1:0]  i_step_count,
    output logic                        o_result_valid,
    output logic [tpw_pkg::NODE_W-1:0]  o_new_position,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tpw_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [tpw_pkg::NODE_W-1:0]  i_cfg_data
);
    import tpw_pkg::*;

    localparam int IDX_W     = $clog2(MAX_NODES + 1);
    localparam int LVL_W     = $clog2(LIFT_LEVELS);
    localparam int ANC_DEPTH = (MAX_NODES + 1) << LVL_W;
    localparam int ANC_AW    = IDX_W + LVL_W;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LIFT_LEVELS - 1);

    // node ids outside 1..MAX_NODES read as the zero sink
    function automatic logic in_rng(input logic [NODE_W-1:0] v);
        return (v != '0) && (32'(v) <= 32'(MAX_NODES));
    endfunction

    function automatic logic [IDX_W-1:0] idx(input logic [NODE_W-1:0] v);
        return in_rng(v) ? IDX_W'(v) : '0;
    endfunction

    t_state r_state, n_state;

    // control
    logic [NODE_W-1:0] r_cnt, n_cnt;
    logic [NODE_W-1:0] r_pos, n_pos;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [LVL_W-1:0]  r_bl, n_bl;
    logic [NODE_W-1:0] r_v, n_v;
    logic              r_anc_z, r_dep_z;

    // walk payload
    logic [NODE_W-1:0] r_tgt, n_tgt;
    logic [STEP_W-1:0] r_t, n_t;
    logic [NODE_W-1:0] r_dpos, n_dpos;
    logic [NODE_W-1:0] r_dtgt, n_dtgt;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b;
    logic [NODE_W-1:0] r_da, n_da, r_db, n_db;
    logic [NODE_W-1:0] r_pa, n_pa;
    logic [NODE_W-1:0] r_dc, n_dc;
    logic [NODE_W-1:0] r_x, n_x;
    logic [STEP_W-1:0] r_len, n_len;
    logic signed [STEP_W+1:0] r_d1, n_d1, r_d2, n_d2, r_t2, n_t2;

    // memory ports
    logic              anc_we, dep_we;
    logic [ANC_AW-1:0] anc_waddr, anc_raddr;
    logic [IDX_W-1:0]  dep_waddr, dep_raddr;
    logic [NODE_W-1:0] anc_wdata, dep_wdata, anc_rdata, dep_rdata;
    logic [NODE_W-1:0] anc_rd_node, dep_rd_node;
    logic [LVL_W-1:0]  anc_rd_lvl;
    logic [NODE_W-1:0] anc_q, dep_q;

    // decisions
    logic              acc;
    logic              move_ok;
    logic [NODE_W-1:0] cnt_eff;
    logic              lvl_zero;
    logic              swap;
    logic              l1_take;
    logic              l2_diff;
    logic [STEP_W-1:0] len_sh;
    logic              cl_bit;
    logic signed [STEP_W+1:0] t_ext;
    logic              go_up;
    logic              at_tgt;

    tpw_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_rdata)
    );

    tpw_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES + 1)) u_dep (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    // sink reads are forced to zero
    assign anc_q = r_anc_z ? '0 : anc_rdata;
    assign dep_q = r_dep_z ? '0 : dep_rdata;

    assign busy           = (r_state != S_IDLE);
    assign acc            = start && (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = (r_state == S_OUT);
    assign o_new_position = r_x;

    assign move_ok  = in_rng(i_node_id) && in_rng(r_pos);
    assign cnt_eff  = (32'(r_cnt) > 32'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_cnt;
    assign lvl_zero = (r_lvl == '0);
    assign swap     = (r_dpos < dep_q);
    assign l1_take  = (dep_q >= r_db);
    assign l2_diff  = (r_pa != anc_q);
    assign len_sh   = r_len >> r_lvl;
    assign cl_bit   = len_sh[0];
    assign t_ext    = $signed({2'b00, r_t});
    assign go_up    = (r_d1 > t_ext);
    assign at_tgt   = (r_t2 >= r_d2);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_op == OP_BUILD && cnt_eff != '0) begin
                        n_state = S_BLD_RD1;
                    end else if (i_op == OP_MOVE && move_ok) begin
                        n_state = S_Q_DP;
                    end
                end
            end
            S_BLD_RD1: n_state = S_BLD_RD2;
            S_BLD_RD2: n_state = S_BLD_WR;
            S_BLD_WR: begin
                if (r_v == cnt_eff && r_bl == LVL_TOP) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_BLD_RD1;
                end
            end
            S_Q_DP:   n_state = S_Q_DT;
            S_Q_DT:   n_state = S_Q_SW;
            S_Q_SW:   n_state = S_L1_RD;
            S_L1_RD:  n_state = S_L1_CMP;
            S_L1_CMP: n_state = lvl_zero ? S_L1_CHK : S_L1_RD;
            S_L1_CHK: n_state = (r_a == r_b) ? S_D1 : S_L2_RB;
            S_L2_RB:  n_state = S_L2_CMP;
            S_L2_CMP: n_state = lvl_zero ? S_F_C : S_L2_RB;
            S_F_C:    n_state = S_F_DC;
            S_F_DC:   n_state = S_D1;
            S_D1:     n_state = S_D2;
            S_D2:     n_state = go_up ? S_CL_ISS : S_D3;
            S_D3:     n_state = at_tgt ? S_OUT : S_CL_ISS;
            S_CL_ISS: begin
                if (cl_bit) begin
                    n_state = S_CL_WAIT;
                end else if (lvl_zero) begin
                    n_state = S_OUT;
                end
            end
            S_CL_WAIT: n_state = lvl_zero ? S_OUT : S_CL_ISS;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt  = r_cnt;
        n_pos  = r_pos;
        n_lvl  = r_lvl;
        n_bl   = r_bl;
        n_v    = r_v;
        n_tgt  = r_tgt;
        n_t    = r_t;
        n_dpos = r_dpos;
        n_dtgt = r_dtgt;
        n_a    = r_a;
        n_b    = r_b;
        n_da   = r_da;
        n_db   = r_db;
        n_pa   = r_pa;
        n_dc   = r_dc;
        n_x    = r_x;
        n_len  = r_len;
        n_d1   = r_d1;
        n_d2   = r_d2;
        n_t2   = r_t2;

        anc_rd_node = r_a;
        anc_rd_lvl  = r_lvl;
        dep_rd_node = r_a;

        anc_we    = 1'b0;
        anc_waddr = {idx(i_node_id), LVL_W'(0)};
        anc_wdata = in_rng(i_parent_id) ? i_parent_id : '0;
        dep_we    = 1'b0;
        dep_waddr = idx(i_node_id);
        dep_wdata = i_node_depth;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: n_cnt = i_cfg_data;
                CFG_START_NODE: n_pos = i_cfg_data;
                default:        n_cnt = r_cnt;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_op == OP_LOAD && in_rng(i_node_id)) begin
                        anc_we = 1'b1;
                        dep_we = 1'b1;
                    end
                    n_v   = NODE_W'(1);
                    n_bl  = LVL_W'(1);
                    n_tgt = i_node_id;
                    n_t   = i_step_count;
                end
            end
            S_BLD_RD1: begin
                anc_rd_node = r_v;
                anc_rd_lvl  = r_bl - LVL_W'(1);
            end
            S_BLD_RD2: begin
                anc_rd_node = anc_q;
                anc_rd_lvl  = r_bl - LVL_W'(1);
            end
            S_BLD_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {idx(r_v), r_bl};
                anc_wdata = anc_q;
                if (r_v == cnt_eff) begin
                    n_v  = NODE_W'(1);
                    n_bl = r_bl + LVL_W'(1);
                end else begin
                    n_v = r_v + NODE_W'(1);
                end
            end
            S_Q_DP: begin
                dep_rd_node = r_pos;
            end
            S_Q_DT: begin
                dep_rd_node = r_tgt;
                n_dpos      = dep_q;
            end
            S_Q_SW: begin
                // deeper node climbs first
                n_dtgt      = dep_q;
                n_a         = swap ? r_tgt : r_pos;
                n_da        = swap ? dep_q : r_dpos;
                n_b         = swap ? r_pos : r_tgt;
                n_db        = swap ? r_dpos : dep_q;
                n_lvl       = LVL_TOP;
                anc_rd_node = swap ? r_tgt : r_pos;
                anc_rd_lvl  = LVL_TOP;
            end
            S_L1_RD: begin
                n_pa        = anc_q;
                dep_rd_node = anc_q;
            end
            S_L1_CMP: begin
                n_a         = l1_take ? r_pa : r_a;
                n_da        = l1_take ? dep_q : r_da;
                anc_rd_node = l1_take ? r_pa : r_a;
                anc_rd_lvl  = r_lvl - LVL_W'(1);
                if (!lvl_zero) begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_L1_CHK: begin
                // same node after leveling: it is the meeting point
                n_dc        = r_da;
                n_lvl       = LVL_TOP;
                anc_rd_node = r_a;
                anc_rd_lvl  = LVL_TOP;
            end
            S_L2_RB: begin
                n_pa        = anc_q;
                anc_rd_node = r_b;
                anc_rd_lvl  = r_lvl;
            end
            S_L2_CMP: begin
                n_a         = l2_diff ? r_pa : r_a;
                n_b         = l2_diff ? anc_q : r_b;
                anc_rd_node = l2_diff ? r_pa : r_a;
                anc_rd_lvl  = lvl_zero ? LVL_W'(0) : r_lvl - LVL_W'(1);
                if (!lvl_zero) begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_F_C: begin
                dep_rd_node = anc_q;
            end
            S_F_DC: begin
                n_dc = dep_q;
            end
            S_D1: begin
                n_d1 = $signed({3'b000, r_dpos}) - $signed({3'b000, r_dc});
                n_d2 = $signed({3'b000, r_dtgt}) - $signed({3'b000, r_dc});
            end
            S_D2: begin
                n_lvl = LVL_TOP;
                if (go_up) begin
                    n_x   = r_pos;
                    n_len = r_t;
                end else begin
                    n_t2 = t_ext - r_d1;
                end
            end
            S_D3: begin
                n_x   = r_tgt;
                n_len = STEP_W'(r_d2 - r_t2);
            end
            S_CL_ISS: begin
                anc_rd_node = r_x;
                anc_rd_lvl  = r_lvl;
                if (!cl_bit && !lvl_zero) begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_CL_WAIT: begin
                n_x = anc_q;
                if (!lvl_zero) begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_OUT: begin
                n_pos = r_x;
            end
            default: n_pos = r_pos;
        endcase

        anc_raddr = {idx(anc_rd_node), anc_rd_lvl};
        dep_raddr = idx(dep_rd_node);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= NODE_W'(1);
            r_pos   <= NODE_W'(1);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_anc_z <= !in_rng(anc_rd_node);
        r_dep_z <= !in_rng(dep_rd_node);
        r_lvl   <= n_lvl;
        r_bl    <= n_bl;
        r_v     <= n_v;
        r_tgt   <= n_tgt;
        r_t     <= n_t;
        r_dpos  <= n_dpos;
        r_dtgt  <= n_dtgt;
        r_a     <= n_a;
        r_b     <= n_b;
        r_da    <= n_da;
        r_db    <= n_db;
        r_pa    <= n_pa;
        r_dc    <= n_dc;
        r_x     <= n_x;
        r_len   <= n_len;
        r_d1    <= n_d1;
        r_d2    <= n_d2;
        r_t2    <= n_t2;
    end
endmodule

FILE: src/tpw_checker.sv
// port-level checks for the tree path walker, bound to the top level
// depends on tpw_pkg
module tpw_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [tpw_pkg::OP_W-1:0] i_op,
    input logic                     o_result_valid
);
    import tpw_pkg::*;

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (!o_result_valid && !busy))
        else $error("result strobe not followed by idle");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_LOAD) |=> !busy)
        else $error("load kept the block busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("not idle after reset");
endmodule

bind tree_path_walker_lca_unit tpw_checker u_tpw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .o_result_valid (o_result_valid)
);

FILE: test/tb.sv
// self-checking testbench for tree_path_walker_lca_unit
// depends on tpw_pkg and the block's rtl; a queue-fed driver and a strobe monitor
`timescale 1ns / 1ps

module tb;
    import tpw_pkg::*;

    localparam int LEVELS = 16;
    localparam int NODE_MAX = 65535;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // longest move plus margin, used as the quiet time before a register write
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] depth;
        logic [STEP_W-1:0] steps;
    } t_walk_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_op = '0;
    logic [NODE_W-1:0]  i_node_id = '0;
    logic [NODE_W-1:0]  i_parent_id = '0;
    logic [NODE_W-1:0]  i_node_depth = '0;
    logic [STEP_W-1:0]  i_step_count = '0;
    logic               o_result_valid;
    logic [NODE_W-1:0]  o_new_position;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index = '0;
    logic [NODE_W-1:0]  i_cfg_data = '0;

    tree_path_walker_lca_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the tree tables and walker registers
    bit [NODE_W-1:0] lift_mem [int unsigned];
    bit [NODE_W-1:0] depth_mem [int unsigned];
    bit [NODE_W-1:0] sh_node_count = 1;
    bit [NODE_W-1:0] sh_position = 1;

    t_walk_item      pending_items [$];
    bit [NODE_W-1:0] expected_positions [$];
    int              mismatches = 0;
    bit              failed = 1'b0;
    int              gap_max = 16;

    function automatic int unsigned lift(int unsigned v, int unsigned lvl);
        if (v > NODE_MAX) v = 0;
        if (lift_mem.exists(v * LEVELS + lvl)) return lift_mem[v * LEVELS + lvl];
        return 0;
    endfunction

    function automatic longint node_depth(int unsigned v);
        if (v > NODE_MAX) v = 0;
        if (depth_mem.exists(v)) return longint'(depth_mem[v]);
        return 0;
    endfunction

    function automatic int unsigned climb_by(int unsigned v, longint len);
        for (int i = LEVELS - 1; i >= 0; i--)
            if ((len >> i) & 1) v = lift(v, i);
        return v;
    endfunction

    function automatic int unsigned common_ancestor(int unsigned a, int unsigned b);
        int unsigned t, p, pa, pb;
        if (node_depth(a) < node_depth(b)) begin
            t = a; a = b; b = t;
        end
        // lift the deeper node to the other's depth
        for (int i = LEVELS - 1; i >= 0; i--) begin
            p = lift(a, i);
            if (node_depth(p) >= node_depth(b)) a = p;
        end
        if (a == b) return a;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            pa = lift(a, i);
            pb = lift(b, i);
            if (pa != pb) begin
                a = pa; b = pb;
            end
        end
        return lift(a, 0);
    endfunction

    // applies one accepted item to the shadow state, queues the expected position
    function automatic void walk_predict(t_walk_item it);
        int unsigned pos, c, res, cnt;
        longint t, d1, d2;
        case (it.op)
            OP_LOAD: begin
                if (it.node != 0) begin
                    lift_mem[it.node * LEVELS] = it.parent;
                    depth_mem[it.node] = it.depth;
                end
            end
            OP_BUILD: begin
                cnt = sh_node_count;
                for (int unsigned lvl = 1; lvl < LEVELS; lvl++)
                    for (int unsigned v = 1; v <= cnt; v++)
                        lift_mem[v * LEVELS + lvl] =
                            NODE_W'(lift(lift(v, lvl - 1), lvl - 1));
            end
            OP_MOVE: begin
                pos = sh_position;
                t = longint'(it.steps);
                if (it.node != 0 && pos != 0) begin
                    c = common_ancestor(pos, it.node);
                    d1 = node_depth(pos) - node_depth(c);
                    if (d1 > t) res = climb_by(pos, t);
                    else begin
                        t -= d1;
                        d2 = node_depth(it.node) - node_depth(c);
                        if (t >= d2) res = it.node;
                        else res = climb_by(it.node, d2 - t);
                    end
                    sh_position = res[NODE_W-1:0];
                    expected_positions = {expected_positions, sh_position};
                end
            end
            default: ;
        endcase
    endfunction

    // driver: one item at a time, random gap after each acceptance
    int gap_left = 0;
    t_walk_item cur_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            walk_predict(cur_item);
            gap_left = $urandom_range(0, gap_max);
            if (gap_left == 0 && pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                i_op <= cur_item.op;
                i_node_id <= cur_item.node;
                i_parent_id <= cur_item.parent;
                i_node_depth <= cur_item.depth;
                i_step_count <= cur_item.steps;
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                i_op <= cur_item.op;
                i_node_id <= cur_item.node;
                i_parent_id <= cur_item.parent;
                i_node_depth <= cur_item.depth;
                i_step_count <= cur_item.steps;
                start <= 1'b1;
            end
        end
    end

    // monitor: every strobe must match the oldest expected position
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_positions.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: new_position %0d", o_new_position);
            end else begin
                if (o_new_position !== expected_positions[0]) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("new_position mismatch: expected %0d actual %0d",
                                 expected_positions[0], o_new_position);
                end
                void'(expected_positions.pop_front());
            end
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, int node, int parent, int depth, int steps);
        t_walk_item it;
        it.op = op;
        it.node = NODE_W'(node);
        it.parent = NODE_W'(parent);
        it.depth = NODE_W'(depth);
        it.steps = STEP_W'(steps);
        pending_items = {pending_items, it};
    endtask

    // wait for every item to be taken, every result seen and the block quiet
    task automatic settle();
        while (pending_items.size() > 0 || start) @(posedge i_clk);
        while (expected_positions.size() > 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, int value);
        i_cfg_index <= idx;
        i_cfg_data <= NODE_W'(value);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT) sh_node_count = NODE_W'(value);
        else begin
            sh_position = NODE_W'(value);
        end
        @(posedge i_clk);
    endtask

    // one well-formed tree of n nodes, a build, then moves, with noise mixed in when noisy is set
    task automatic run_phase(int n, int shape, int moves, bit noisy);
        int gen_depth [int];
        int par, maxd, tgt, st;
        settle();
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_START_NODE, $urandom_range(1, n));
        maxd = 1;
        gen_depth[1] = 1;
        push_item(OP_LOAD, 1, 1, 1, $urandom_range(0, 131071));
        for (int v = 2; v <= n; v++) begin
            case (shape)
                0: par = v - 1;             // chain, deep lifts
                1: par = 1;                 // star
                default: par = $urandom_range(1, v - 1);
            endcase
            gen_depth[v] = gen_depth[par] + 1;
            if (gen_depth[v] > maxd) maxd = gen_depth[v];
            push_item(OP_LOAD, v, par, gen_depth[v], $urandom_range(0, 131071));
        end
        // inconsistent reload: parent stays in the tree, depth is arbitrary
        if (noisy && n > 1)
            push_item(OP_LOAD, $urandom_range(2, n), $urandom_range(1, n),
                      $urandom_range(0, 65535), 0);
        push_item(OP_BUILD, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 131071));
        for (int k = 0; k < moves; k++) begin
            tgt = $urandom_range(1, n);
            st = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                             : $urandom_range(0, 2 * maxd + 2);
            push_item(OP_MOVE, tgt, $urandom_range(0, 65535), $urandom_range(0, 65535), st);
            if (noisy && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: push_item(OP_SPARE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 131071));
                    1: push_item(OP_MOVE, 0, $urandom_range(0, 65535), 0,
                                 $urandom_range(0, 131071));
                    default: push_item(OP_LOAD, 0, $urandom_range(0, 65535),
                                       $urandom_range(0, 65535), 0);
                endcase
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register extremes, overwritten before anything reads them
        write_reg(CFG_NODE_COUNT, 65535);
        write_reg(CFG_START_NODE, 65535);
        write_reg(CFG_NODE_COUNT, 5);
        write_reg(CFG_START_NODE, 3);

        // directed: ignored items, field extremes, small fixed tree
        push_item(OP_LOAD, 0, 7, 9, 0);
        push_item(OP_LOAD, 65535, 65535, 65535, 131071);
        push_item(OP_SPARE, 65535, 65535, 65535, 131071);
        push_item(OP_LOAD, 1, 1, 1, 0);
        push_item(OP_LOAD, 2, 1, 2, 0);
        push_item(OP_LOAD, 3, 2, 3, 0);
        push_item(OP_LOAD, 4, 1, 2, 0);
        push_item(OP_LOAD, 5, 4, 3, 0);
        push_item(OP_BUILD, 0, 0, 0, 0);
        push_item(OP_MOVE, 3, 0, 0, 0);        // target is the position
        push_item(OP_MOVE, 5, 0, 0, 2);        // stop at the common ancestor
        push_item(OP_MOVE, 5, 0, 0, 131071);   // count past the target
        push_item(OP_MOVE, 0, 0, 0, 3);        // bad target, no result
        push_item(OP_MOVE, 3, 0, 0, 1);        // part way up, short of the common ancestor
        push_item(OP_MOVE, 1, 0, 0, 65536);    // jump bits above the lift levels
        push_item(OP_MOVE, 2, 65535, 65535, 0);
        push_item(OP_MOVE, 4, 0, 0, 3);
        push_item(OP_MOVE, 3, 0, 0, 1);

        // pressure and a single-node tree at the count's low extreme
        run_phase(1, 2, 6, 1'b1);
        run_phase(400, 0, 30, 1'b0);
        for (int p = 0; p < 21; p++)
            run_phase($urandom_range(2, 40), $urandom_range(0, 4), $urandom_range(25, 40),
                      1'($urandom_range(0, 1)));
        settle();

        if (!failed && expected_positions.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
